FILE: design/axis_angle_to_rotation_matrix_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, ignored while reset is low.
`define AARM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is low.
`define AARM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_N       = 40;
    localparam int AW           = $clog2(ATAN_N);
    localparam int SQRT_STEPS   = 32;
    localparam int SQW          = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS    = 31;
    localparam int AXES         = 3;
    localparam int CW           = 34;
    localparam int LAT          = 73 + CORDIC_STEPS;

    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_Q30 = 34'sd536870912;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] TWO_PI_X2  = 32'd3373259426;
    localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
    localparam logic signed [31:0] TWO_PI_S  = 32'sd1686629713;
    localparam logic signed [31:0] PI_S      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_S = 32'sd421657428;
    localparam logic [25:0] TWENTYFOURTH_Q30 = 26'd44739243;
    localparam logic [27:0] SIXTH_Q30        = 28'd178956971;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } t_rot_in;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } t_mat_out;

    typedef struct packed {
        logic [32:0]          p;
        logic [DIV_STEPS-1:0] q;
    } t_div_lane;

    function automatic logic [29:0] atan_val(input logic [AW-1:0] i);
        unique case (i)
            6'd0:  atan_val = 30'd843314856;
            6'd1:  atan_val = 30'd497837829;
            6'd2:  atan_val = 30'd263043836;
            6'd3:  atan_val = 30'd133525158;
            6'd4:  atan_val = 30'd67021686;
            6'd5:  atan_val = 30'd33543515;
            6'd6:  atan_val = 30'd16775850;
            6'd7:  atan_val = 30'd8388437;
            6'd8:  atan_val = 30'd4194282;
            6'd9:  atan_val = 30'd2097149;
            6'd10: atan_val = 30'd1048575;
            6'd11: atan_val = 30'd524287;
            6'd12: atan_val = 30'd262143;
            6'd13: atan_val = 30'd131071;
            6'd14: atan_val = 30'd65535;
            6'd15: atan_val = 30'd32767;
            6'd16: atan_val = 30'd16383;
            6'd17: atan_val = 30'd8191;
            6'd18: atan_val = 30'd4095;
            6'd19: atan_val = 30'd2047;
            6'd20: atan_val = 30'd1023;
            6'd21: atan_val = 30'd511;
            6'd22: atan_val = 30'd255;
            6'd23: atan_val = 30'd127;
            6'd24: atan_val = 30'd63;
            6'd25: atan_val = 30'd31;
            6'd26: atan_val = 30'd15;
            6'd27: atan_val = 30'd7;
            6'd28: atan_val = 30'd3;
            6'd29: atan_val = 30'd1;
            default: atan_val = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: design/aarm_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module aarm_sqrt_cell import aarm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [SQW-1:0] i_stage,
    input  logic [63:0]    i_n,
    input  logic [63:0]    i_r,
    output logic [63:0]    o_n,
    output logic [63:0]    o_r
);

    logic [SQW+1:0] w_sh;
    logic [63:0]    w_b;
    logic [63:0]    w_t;
    logic [63:0]    n_n;
    logic [63:0]    n_r;
    logic [63:0]    r_n;
    logic [63:0]    r_r;

    assign w_sh = (SQW+2)'(2 * SQRT_STEPS - 2) - {1'b0, i_stage, 1'b0};
    assign w_b  = 64'd1 << w_sh;
    assign w_t  = i_r + w_b;

    always_comb begin
        if (i_n >= w_t) begin
            n_n = i_n - w_t;
            n_r = (i_r >> 1) + w_b;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n;
            r_r <= n_r;
        end
    end

    assign o_n = r_n;
    assign o_r = r_r;

endmodule
`default_nettype wire

FILE: design/aarm_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module aarm_div_cell import aarm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_d,
    input  t_div_lane [AXES-1:0] i_lane,
    output logic [31:0]          o_d,
    output t_div_lane [AXES-1:0] o_lane
);

    logic [32:0]          w_diff [AXES];
    t_div_lane [AXES-1:0] n_lane;
    t_div_lane [AXES-1:0] r_lane;
    logic [31:0]          r_d;

    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            w_diff[j] = i_lane[j].p - {1'b0, i_d};
            if (i_lane[j].p >= {1'b0, i_d}) begin
                n_lane[j].p = {w_diff[j][31:0], 1'b0};
                n_lane[j].q = {i_lane[j].q[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_lane[j].p = {i_lane[j].p[31:0], 1'b0};
                n_lane[j].q = {i_lane[j].q[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_d    <= i_d;
        end
    end

    assign o_lane = r_lane;
    assign o_d    = r_d;

endmodule
`default_nettype wire

FILE: design/aarm_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module aarm_cordic_cell import aarm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [AW-1:0]        i_step,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z
);

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] w_a;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    assign w_xs = i_x >>> i_step;
    assign w_ys = i_y >>> i_step;
    assign w_a  = $signed({4'b0, atan_val(i_step)});

    always_comb begin
        if (!i_z[CW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_a;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

FILE: design/axis_angle_to_rotation_matrix.sv
// Rotation vector (Q3.28) to 3x3 rotation matrix (Q1.30, saturated) by the
// Rodrigues formula. Fully pipelined: one beat in and one beat out per cycle
// while the output is not stalled. The pipe is made up of a 32-cell
// square-root chain, a 31-cell divider chain for the axis, a CORDIC chain of
// CORDIC_STEPS cells and further stages for reduction and the matrix products.
// The whole pipe holds when a result beat waits and the consumer is not ready.
// Write small_angle_limit only while no beat is in flight: each beat compares
// against it deep inside the pipe, after its square root.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_to_rotation_matrix import aarm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_rot_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_mat_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_data
);

    typedef struct packed {
        t_rot_in     rot;
        logic [15:0] sq;
    } t_side_a;

    typedef struct packed {
        t_rot_in     rot;
        logic        small_ang;
        logic [15:0] sq;
        logic [41:0] pa;
        logic [43:0] pb;
    } t_side_b;

    typedef struct packed {
        logic signed [31:0]   u_x;
        logic signed [31:0]   u_y;
        logic signed [31:0]   u_z;
        logic signed [CW-1:0] c_s;
        logic signed [CW-1:0] v_s;
        logic signed [CW-1:0] s_s;
        logic                 small_ang;
        logic                 neg;
    } t_side_c;

    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        return p[CW+29:30];
    endfunction

    function automatic logic [31:0] sat(input logic signed [CW:0] v);
        if (v > 35'sd1073741824) begin
            return 32'h4000_0000;
        end else if (v < -35'sd1073741824) begin
            return 32'hC000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [32:0] mag(input logic signed [31:0] a);
        logic signed [32:0] e;
        e = {a[31], a};
        return a[31] ? -e : e;
    endfunction

    function automatic logic signed [31:0] apply_sign(input logic s,
                                                      input logic [DIV_STEPS-1:0] q);
        logic signed [31:0] e;
        e = $signed({1'b0, q});
        return s ? -e : e;
    endfunction

    function automatic logic signed [CW-1:0] ext(input logic signed [31:0] a);
        return {{(CW-32){a[31]}}, a};
    endfunction

    logic            w_en;
    logic            w_accept;
    logic [LAT-1:0]  r_vld;
    logic [LAT-1:0]  n_vld;
    logic [20:0]     r_limit;

    // stage 1 and 2
    t_rot_in         r_s1_rot;
    logic [62:0]     r_s1_px;
    logic [62:0]     r_s1_py;
    logic [62:0]     r_s1_pz;
    logic signed [63:0] w_px;
    logic signed [63:0] w_py;
    logic signed [63:0] w_pz;
    logic [63:0]     w_sum;
    logic [63:0]     r_s2_n;
    t_side_a         r_s2_side;

    // square root chain
    logic [63:0]     w_n [0:SQRT_STEPS];
    logic [63:0]     w_r [0:SQRT_STEPS];
    t_side_a         r_sq_side [0:SQRT_STEPS-1];
    logic [31:0]     w_ang;

    // divider chain
    t_side_b         r_e_side;
    logic [31:0]     r_e_d;
    t_div_lane [AXES-1:0] w_dl [0:DIV_STEPS];
    logic [31:0]     w_dd [0:DIV_STEPS];
    t_side_b         r_dv_side [0:DIV_STEPS-1];
    t_side_b         w_dv;

    // reduction
    t_side_c         r_u_side;
    t_side_c         n_u_side;
    logic [31:0]     r_u_t;
    t_side_c         r_m2_side;
    logic [30:0]     r_m2_t;
    t_side_c         r_m3_side;
    t_side_c         n_m3_side;
    logic signed [CW-1:0] r_m3_z;
    logic signed [CW-1:0] n_m3_z;
    logic signed [31:0]   w_ts;

    // cordic chain
    logic signed [CW-1:0] w_x [0:CORDIC_STEPS];
    logic signed [CW-1:0] w_y [0:CORDIC_STEPS];
    logic signed [CW-1:0] w_z [0:CORDIC_STEPS];
    t_side_c         r_cd_side [0:CORDIC_STEPS-1];
    t_side_c         w_cd;
    logic signed [CW-1:0] w_cn;
    logic signed [CW-1:0] w_sn;

    // matrix stages
    logic signed [CW-1:0] r_f0_u [AXES];
    logic signed [CW-1:0] r_f0_c;
    logic signed [CW-1:0] r_f0_s;
    logic signed [CW-1:0] r_f0_v;
    logic signed [CW-1:0] r_f1_p [6];
    logic signed [CW-1:0] r_f1_us [AXES];
    logic signed [CW-1:0] r_f1_c;
    logic signed [CW-1:0] r_f1_v;
    logic signed [CW-1:0] r_f2_pv [6];
    logic signed [CW-1:0] r_f2_us [AXES];
    logic signed [CW-1:0] r_f2_c;
    t_mat_out        r_out;
    t_mat_out        n_out;

    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign w_accept   = i_in_valid && w_en;
    assign o_in_ready = w_en;
    assign n_vld      = {r_vld[LAT-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_limit <= '0;
        end else begin
            if (w_en) begin
                r_vld <= n_vld;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    assign w_px  = i_in_data.rot_x * i_in_data.rot_x;
    assign w_py  = i_in_data.rot_y * i_in_data.rot_y;
    assign w_pz  = i_in_data.rot_z * i_in_data.rot_z;
    assign w_sum = {1'b0, r_s1_px} + {1'b0, r_s1_py} + {1'b0, r_s1_pz};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_rot       <= i_in_data;
            r_s1_px        <= w_px[62:0];
            r_s1_py        <= w_py[62:0];
            r_s1_pz        <= w_pz[62:0];
            r_s2_n         <= w_sum;
            r_s2_side.rot  <= r_s1_rot;
            r_s2_side.sq   <= w_sum[41:26];
        end
    end

    assign w_n[0] = r_s2_n;
    assign w_r[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        aarm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (SQW'(k)),
            .i_n     (w_n[k]),
            .i_r     (w_r[k]),
            .o_n     (w_n[k+1]),
            .o_r     (w_r[k+1])
        );
    end

    assign w_ang = w_r[SQRT_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= r_s2_side;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
            r_e_d               <= w_ang;
            r_e_side.rot        <= r_sq_side[SQRT_STEPS-1].rot;
            r_e_side.sq         <= r_sq_side[SQRT_STEPS-1].sq;
            r_e_side.small_ang  <= (w_ang <= {11'b0, r_limit});
            r_e_side.pa         <= {26'b0, r_sq_side[SQRT_STEPS-1].sq} *
                                   {16'b0, TWENTYFOURTH_Q30};
            r_e_side.pb         <= {28'b0, r_sq_side[SQRT_STEPS-1].sq} *
                                   {16'b0, SIXTH_Q30};
        end
    end

    assign w_dd[0]      = r_e_d;
    assign w_dl[0][0].p = mag(r_e_side.rot.rot_x);
    assign w_dl[0][1].p = mag(r_e_side.rot.rot_y);
    assign w_dl[0][2].p = mag(r_e_side.rot.rot_z);
    assign w_dl[0][0].q = '0;
    assign w_dl[0][1].q = '0;
    assign w_dl[0][2].q = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        aarm_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_d    (w_dd[k]),
            .i_lane (w_dl[k]),
            .o_d    (w_dd[k+1]),
            .o_lane (w_dl[k+1])
        );
    end

    assign w_dv = r_dv_side[DIV_STEPS-1];

    always_comb begin
        n_u_side.small_ang = w_dv.small_ang;
        n_u_side.neg       = 1'b0;
        n_u_side.c_s       = ONE_Q30 - $signed({19'b0, w_dv.sq[15:1]});
        n_u_side.v_s       = HALF_Q30 - $signed({22'b0, w_dv.pa[41:30]});
        n_u_side.s_s       = ONE_Q30 - $signed({20'b0, w_dv.pb[43:30]});
        if (w_dv.small_ang) begin
            n_u_side.u_x = w_dv.rot.rot_x <<< 2;
            n_u_side.u_y = w_dv.rot.rot_y <<< 2;
            n_u_side.u_z = w_dv.rot.rot_z <<< 2;
        end else begin
            n_u_side.u_x = apply_sign(w_dv.rot.rot_x[31], w_dl[DIV_STEPS][0].q);
            n_u_side.u_y = apply_sign(w_dv.rot.rot_y[31], w_dl[DIV_STEPS][1].q);
            n_u_side.u_z = apply_sign(w_dv.rot.rot_z[31], w_dl[DIV_STEPS][2].q);
        end
    end

    always_comb begin
        w_ts = (r_m2_t > PI_S[30:0]) ? $signed({1'b0, r_m2_t}) - TWO_PI_S
                                      : $signed({1'b0, r_m2_t});
        n_m3_side = r_m2_side;
        if (w_ts > HALF_PI_S) begin
            n_m3_side.neg = 1'b1;
            n_m3_z        = {w_ts - PI_S, 2'b00};
        end else if (w_ts < -HALF_PI_S) begin
            n_m3_side.neg = 1'b1;
            n_m3_z        = {w_ts + PI_S, 2'b00};
        end else begin
            n_m3_side.neg = 1'b0;
            n_m3_z        = {w_ts, 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0] <= r_e_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
            r_u_side  <= n_u_side;
            r_u_t     <= (w_dd[DIV_STEPS] >= TWO_PI_X2) ? w_dd[DIV_STEPS] - TWO_PI_X2
                                                        : w_dd[DIV_STEPS];
            r_m2_side <= r_u_side;
            r_m2_t    <= (r_u_t >= TWO_PI_Q28) ? 31'(r_u_t - TWO_PI_Q28) : r_u_t[30:0];
            r_m3_side <= n_m3_side;
            r_m3_z    <= n_m3_z;
        end
    end

    assign w_x[0] = GAIN_Q30;
    assign w_y[0] = '0;
    assign w_z[0] = r_m3_z;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        aarm_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (AW'(k)),
            .i_x    (w_x[k]),
            .i_y    (w_y[k]),
            .i_z    (w_z[k]),
            .o_x    (w_x[k+1]),
            .o_y    (w_y[k+1]),
            .o_z    (w_z[k+1])
        );
    end

    assign w_cd = r_cd_side[CORDIC_STEPS-1];
    assign w_cn = w_cd.neg ? -w_x[CORDIC_STEPS] : w_x[CORDIC_STEPS];
    assign w_sn = w_cd.neg ? -w_y[CORDIC_STEPS] : w_y[CORDIC_STEPS];

    always_comb begin
        n_out.m00 = sat({r_f2_pv[0][CW-1], r_f2_pv[0]} + {r_f2_c[CW-1], r_f2_c});
        n_out.m11 = sat({r_f2_pv[1][CW-1], r_f2_pv[1]} + {r_f2_c[CW-1], r_f2_c});
        n_out.m22 = sat({r_f2_pv[2][CW-1], r_f2_pv[2]} + {r_f2_c[CW-1], r_f2_c});
        n_out.m01 = sat({r_f2_pv[3][CW-1], r_f2_pv[3]} - {r_f2_us[2][CW-1], r_f2_us[2]});
        n_out.m10 = sat({r_f2_pv[3][CW-1], r_f2_pv[3]} + {r_f2_us[2][CW-1], r_f2_us[2]});
        n_out.m02 = sat({r_f2_pv[4][CW-1], r_f2_pv[4]} + {r_f2_us[1][CW-1], r_f2_us[1]});
        n_out.m20 = sat({r_f2_pv[4][CW-1], r_f2_pv[4]} - {r_f2_us[1][CW-1], r_f2_us[1]});
        n_out.m12 = sat({r_f2_pv[5][CW-1], r_f2_pv[5]} - {r_f2_us[0][CW-1], r_f2_us[0]});
        n_out.m21 = sat({r_f2_pv[5][CW-1], r_f2_pv[5]} + {r_f2_us[0][CW-1], r_f2_us[0]});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd_side[0] <= r_m3_side;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_cd_side[k] <= r_cd_side[k-1];
            end
            r_f0_u[0] <= ext(w_cd.u_x);
            r_f0_u[1] <= ext(w_cd.u_y);
            r_f0_u[2] <= ext(w_cd.u_z);
            r_f0_c    <= w_cd.small_ang ? w_cd.c_s : w_cn;
            r_f0_s    <= w_cd.small_ang ? w_cd.s_s : w_sn;
            r_f0_v    <= w_cd.small_ang ? w_cd.v_s : ONE_Q30 - w_cn;

            r_f1_p[0] <= qmul(r_f0_u[0], r_f0_u[0]);
            r_f1_p[1] <= qmul(r_f0_u[1], r_f0_u[1]);
            r_f1_p[2] <= qmul(r_f0_u[2], r_f0_u[2]);
            r_f1_p[3] <= qmul(r_f0_u[0], r_f0_u[1]);
            r_f1_p[4] <= qmul(r_f0_u[0], r_f0_u[2]);
            r_f1_p[5] <= qmul(r_f0_u[1], r_f0_u[2]);
            for (int j = 0; j < AXES; j++) begin
                r_f1_us[j] <= qmul(r_f0_u[j], r_f0_s);
                r_f2_us[j] <= r_f1_us[j];
            end
            r_f1_c <= r_f0_c;
            r_f1_v <= r_f0_v;

            for (int j = 0; j < 6; j++) begin
                r_f2_pv[j] <= qmul(r_f1_p[j], r_f1_v);
            end
            r_f2_c <= r_f1_c;

            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: design/aarm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_to_rotation_matrix_defines.svh"
module aarm_checker import aarm_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire t_rot_in     i_in_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_mat_out    o_out_data,
    input wire logic        i_cfg_we,
    input wire logic [20:0] i_cfg_data
);

    `AARM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat dropped or changed while stalled")

    `AARM_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input held off without an output stall")

    `AARM_ASSERT_NOW(a_diag_range, i_clk, i_rst_n, o_out_valid, (o_out_data.m00 <= 32'sd1073741824) && (o_out_data.m00 >= -32'sd1073741824) && (o_out_data.m11 <= 32'sd1073741824) && (o_out_data.m11 >= -32'sd1073741824) && (o_out_data.m22 <= 32'sd1073741824) && (o_out_data.m22 >= -32'sd1073741824), "diagonal entry beyond saturation")

    `AARM_ASSERT_NOW(a_ready_on_take, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready, "input held off while a result beat leaves")

endmodule

bind axis_angle_to_rotation_matrix aarm_checker u_aarm_checker (.*);
`default_nettype wire
